// File: rtl/ngahr_pkg.sv
// ----------------------------------------------------------------------------
// ngahr_pkg
// Shared widths, register indexes and the configuration bundle of the noise
// gate with attack, hold and release smoothing.
// ----------------------------------------------------------------------------
package ngahr_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int THR_W      = 24;
    localparam int COEF_W     = 16;
    localparam int HOLD_W     = 20;
    localparam int MAKEUP_W   = 21;
    localparam int GAIN_OUT_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ITEM_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD     = 3'd0,
        REG_ALPHA_ATTACK  = 3'd1,
        REG_ALPHA_RELEASE = 3'd2,
        REG_HOLD_SAMPLES  = 3'd3,
        REG_MAKEUP_GAIN   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        [THR_W-1:0]    threshold_level;
        logic        [COEF_W-1:0]   alpha_attack;
        logic        [COEF_W-1:0]   alpha_release;
        logic        [HOLD_W-1:0]   hold_samples;
        logic signed [MAKEUP_W-1:0] makeup_gain;
    } cfg_t;

endpackage

// File: rtl/noise_gate_attack_hold_release.sv
// Noise gate with attack, hold and release smoothing. Each item is one signed
// sample and gives one result: the sample scaled by the smoothed gate gain
// plus makeup, rounded half up and saturated, together with the new smoothed
// gain. The gain recursion takes one item at a time, registering the product
// in its load state and updating the gain in its update state, which waits
// while the scaling pipeline is full; the output multiply runs in its own
// pipeline stages behind it. The user must write registers through the plain
// write port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
// noise_gate_attack_hold_release
// Top level: configuration registers, sample classifier and gain unit.
// ----------------------------------------------------------------------------
module noise_gate_attack_hold_release #(
    parameter int SAMPLE_WIDTH   = ngahr_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ngahr_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ngahr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ngahr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 push,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    output logic                                 full,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic [ngahr_pkg::GAIN_OUT_W-1:0]     gate_gain
);

    ngahr_pkg::cfg_t             cfg_reg;
    logic                        item_valid;
    logic signed [SAMPLE_WIDTH-1:0] item_sample;
    logic                        item_open;
    logic                        item_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ngahr_pkg::REG_THRESHOLD:
                    cfg_reg.threshold_level <= cfg_data[ngahr_pkg::THR_W-1:0];
                ngahr_pkg::REG_ALPHA_ATTACK:
                    cfg_reg.alpha_attack <= cfg_data[ngahr_pkg::COEF_W-1:0];
                ngahr_pkg::REG_ALPHA_RELEASE:
                    cfg_reg.alpha_release <= cfg_data[ngahr_pkg::COEF_W-1:0];
                ngahr_pkg::REG_HOLD_SAMPLES:
                    cfg_reg.hold_samples <= cfg_data[ngahr_pkg::HOLD_W-1:0];
                ngahr_pkg::REG_MAKEUP_GAIN:
                    cfg_reg.makeup_gain <= $signed(cfg_data[ngahr_pkg::MAKEUP_W-1:0]);
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    ngahr_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_level (cfg_reg.threshold_level),
        .push            (push),
        .sample_in       (sample_in),
        .full            (full),
        .item_pop        (item_pop),
        .item_valid      (item_valid),
        .item_sample     (item_sample),
        .item_open       (item_open)
    );

    ngahr_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item_sample (item_sample),
        .item_open   (item_open),
        .item_pop    (item_pop),
        .pop         (pop),
        .empty       (empty),
        .sample_out  (sample_out),
        .gate_gain   (gate_gain)
    );

endmodule

// File: rtl/ngahr_fifo.sv
// ----------------------------------------------------------------------------
// ngahr_fifo
// Small flip-flop queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ngahr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   CAP  = (AW + 1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CAP);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ngahr_front.sv
// ----------------------------------------------------------------------------
// ngahr_front
// Takes samples, classifies each against the threshold and queues it for
// the gain unit.
// ----------------------------------------------------------------------------
module ngahr_front #(
    parameter int SAMPLE_WIDTH = ngahr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ngahr_pkg::THR_W-1:0]    threshold_level,
    input  logic                           push,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           full,
    input  logic                           item_pop,
    output logic                           item_valid,
    output logic signed [SAMPLE_WIDTH-1:0] item_sample,
    output logic                           item_open
);

    localparam int CW = (SAMPLE_WIDTH > ngahr_pkg::THR_W) ? SAMPLE_WIDTH : ngahr_pkg::THR_W;

    logic [SAMPLE_WIDTH-1:0] mag;
    logic                    open;
    logic [SAMPLE_WIDTH:0]   q_in;
    logic [SAMPLE_WIDTH:0]   q_out;
    logic                    q_empty;

    // most negative sample wraps to 2^(w-1) when read unsigned
    assign mag  = sample_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample_in)
                                            : SAMPLE_WIDTH'(sample_in);
    assign open = !(CW'(mag) < CW'(threshold_level));
    assign q_in = {open, sample_in};

    ngahr_fifo #(
        .WIDTH (SAMPLE_WIDTH + 1),
        .DEPTH (ngahr_pkg::ITEM_QUEUE_DEPTH)
    ) u_item_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (item_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign item_valid  = !q_empty;
    assign item_open   = q_out[SAMPLE_WIDTH];
    assign item_sample = $signed(q_out[SAMPLE_WIDTH-1:0]);

endmodule

// File: rtl/ngahr_back.sv
// ----------------------------------------------------------------------------
// ngahr_back
// Gain recursion with hold counter, followed by the makeup and output
// scaling pipeline and the result queue.
// ----------------------------------------------------------------------------
module ngahr_back #(
    parameter int SAMPLE_WIDTH   = ngahr_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ngahr_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ngahr_pkg::cfg_t                     cfg,
    input  logic                                item_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]      item_sample,
    input  logic                                item_open,
    output logic                                item_pop,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic [ngahr_pkg::GAIN_OUT_W-1:0]    gate_gain
);

    localparam int F    = GAIN_FRAC_BITS;
    localparam int SW   = SAMPLE_WIDTH;
    localparam int GW   = F + 1;
    localparam int PGW  = 2 * F + 2;
    localparam int HCW  = ngahr_pkg::HOLD_W + 1;
    localparam int MKW  = ngahr_pkg::MAKEUP_W;
    localparam int TW   = ((F + 2 > MKW) ? F + 2 : MKW) + 1;
    localparam int PW   = SW + TW;
    localparam int YW   = PW - F;
    localparam int GOW  = ngahr_pkg::GAIN_OUT_W;
    localparam int GXW  = (GW > GOW) ? GW : GOW;
    localparam int CXW  = (GW > ngahr_pkg::COEF_W) ? GW : ngahr_pkg::COEF_W;
    localparam int RW   = GOW + SW;

    localparam logic [GW-1:0]  ONE      = GW'(1) << F;
    localparam logic [PGW-1:0] HALF_G   = PGW'(1) << (F - 1);
    localparam logic [PW-1:0]  HALF_P   = PW'(1) << (F - 1);
    localparam logic [YW-1:0]  HI_U     = {{(YW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic [YW-1:0]  LO_U     = ~HI_U;

    typedef enum logic {S_LOAD, S_UPD} state_t;
    typedef enum logic [1:0] {STEP_HOLD, STEP_ATTACK, STEP_RELEASE} step_t;

    state_t                 state_reg;
    step_t                  step_reg;
    logic [GW-1:0]          gain_reg;
    logic [HCW-1:0]         hold_count_reg;
    logic [PGW-1:0]         prod_g_reg;
    logic [GW-1:0]          one_minus_a_reg;
    logic                   open_reg;
    logic signed [SW-1:0]   sample_reg;

    logic                   st0_valid_reg;
    logic signed [SW-1:0]   st0_sample_reg;
    logic signed [TW-1:0]   st0_total_reg;
    logic [GW-1:0]          st0_gain_reg;
    logic                   st1_valid_reg;
    logic signed [PW-1:0]   st1_prod_reg;
    logic [GW-1:0]          st1_gain_reg;

    logic [HCW-1:0]         hold_ext;
    logic [HCW-1:0]         hc_next;
    step_t                  step_next;
    logic [CXW-1:0]         coef_x;
    logic [GW-1:0]          a_q;
    logic [PGW-1:0]         acc;
    logic [GW-1:0]          gain_next;
    logic signed [TW-1:0]   total_next;
    logic signed [PW-1:0]   prod_p;
    logic signed [PW-1:0]   rounded;
    logic signed [YW-1:0]   y;
    logic signed [SW-1:0]   y_sat;
    logic [GXW-1:0]         gain_x;
    logic [RW-1:0]          res_in;
    logic [RW-1:0]          res_out;
    logic                   res_full;
    logic                   res_push;
    logic                   st1_free;
    logic                   move01;
    logic                   st0_free;
    logic                   do_load;
    logic                   do_upd;

    // hold counter and step choice
    assign hold_ext = HCW'(cfg.hold_samples);

    always_comb
    begin
        hc_next = (hold_count_reg > hold_ext) ? hold_ext + 1'b1 : hold_count_reg + 1'b1;
        if (hc_next <= hold_ext)
        begin
            step_next = STEP_HOLD;
        end
        else if (!item_open || (gain_reg == ONE))
        begin
            step_next = STEP_ATTACK;
        end
        else
        begin
            step_next = STEP_RELEASE;
        end
    end

    assign coef_x = (step_next == STEP_ATTACK) ? CXW'(cfg.alpha_attack)
                                               : CXW'(cfg.alpha_release);
    assign a_q    = (coef_x > CXW'(ONE)) ? ONE : GW'(coef_x);

    // smoothing update from the registered product
    assign acc = prod_g_reg + (open_reg ? PGW'({one_minus_a_reg, {F{1'b0}}}) : '0) + HALF_G;

    always_comb
    begin
        case (step_reg)
            STEP_HOLD: gain_next = gain_reg;
            default:   gain_next = acc[2*F:F];
        endcase
    end

    assign total_next = TW'($signed({1'b0, gain_next})) + TW'(cfg.makeup_gain);

    // scaling pipeline flow
    assign res_push = st1_valid_reg && !res_full;
    assign st1_free = !st1_valid_reg || res_push;
    assign move01   = st0_valid_reg && st1_free;
    assign st0_free = !st0_valid_reg || move01;
    assign do_load  = (state_reg == S_LOAD) && item_valid;
    assign do_upd   = (state_reg == S_UPD) && st0_free;
    assign item_pop = do_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            step_reg        <= STEP_HOLD;
            gain_reg        <= ONE;
            hold_count_reg  <= '0;
            prod_g_reg      <= '0;
            one_minus_a_reg <= '0;
            open_reg        <= 1'b0;
            sample_reg      <= '0;
            st0_valid_reg   <= 1'b0;
            st0_sample_reg  <= '0;
            st0_total_reg   <= '0;
            st0_gain_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (do_load)
                    begin
                        step_reg        <= step_next;
                        hold_count_reg  <= (step_next == STEP_RELEASE) ? '0 : hc_next;
                        prod_g_reg      <= PGW'(a_q) * PGW'(gain_reg);
                        one_minus_a_reg <= ONE - a_q;
                        open_reg        <= item_open;
                        sample_reg      <= item_sample;
                        state_reg       <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (do_upd)
                    begin
                        gain_reg  <= gain_next;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase

            if (do_upd)
            begin
                st0_valid_reg  <= 1'b1;
                st0_sample_reg <= sample_reg;
                st0_total_reg  <= total_next;
                st0_gain_reg   <= gain_next;
            end
            else if (move01)
            begin
                st0_valid_reg <= 1'b0;
            end
        end
    end

    assign prod_p = st0_sample_reg * st0_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st1_prod_reg  <= '0;
            st1_gain_reg  <= '0;
        end
        else
        begin
            if (move01)
            begin
                st1_valid_reg <= 1'b1;
                st1_prod_reg  <= prod_p;
                st1_gain_reg  <= st0_gain_reg;
            end
            else if (res_push)
            begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    // round half up, then saturate
    assign rounded = st1_prod_reg + $signed(HALF_P);
    assign y       = YW'(rounded >>> F);

    always_comb
    begin
        if (y > $signed(HI_U))
        begin
            y_sat = $signed(HI_U[SW-1:0]);
        end
        else if (y < $signed(LO_U))
        begin
            y_sat = $signed(LO_U[SW-1:0]);
        end
        else
        begin
            y_sat = y[SW-1:0];
        end
    end

    assign gain_x = GXW'(st1_gain_reg);
    assign res_in = {gain_x[GOW-1:0], y_sat};

    ngahr_fifo #(
        .WIDTH (RW),
        .DEPTH (ngahr_pkg::RESULT_QUEUE_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign sample_out = $signed(res_out[SW-1:0]);
    assign gate_gain  = res_out[RW-1:SW];

endmodule
